@@ sv/pba_pkg.sv @@
// Package for the page bitmap allocator: sizes, codes and state type.
`default_nettype none
package pba_pkg;
  localparam int NUM_PAGES = 4096;
  localparam int MAP_WORD_BITS = 64;
  localparam int MAP_WORDS = (NUM_PAGES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int WADDR_W = $clog2(MAP_WORDS);
  localparam int BIT_W = $clog2(MAP_WORD_BITS);
  localparam int PAGE_W = 12;
  localparam int COUNT_W = 13;

  localparam logic [1:0] OP_ALLOC_ANY = 2'd0;
  localparam logic [1:0] OP_ALLOC_AT  = 2'd1;
  localparam logic [1:0] OP_FREE      = 2'd2;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_NO_ROOM    = 3'd1;
  localparam logic [2:0] ST_USED       = 3'd2;
  localparam logic [2:0] ST_RANGE      = 3'd3;
  localparam logic [2:0] ST_FREED_FREE = 3'd4;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_SCAN, S_MARK, S_DONE
  } pba_state_t;
endpackage
`default_nettype wire

@@ sv/page_bitmap_allocator_unit.sv @@
// Top level of the page bitmap allocator: request sequencer around the bitmap memory.
// The page bitmap allocator keeps one in-use bit per page in a memory of
// MAP_WORDS words of MAP_WORD_BITS bits. After reset a clearing pass writes
// every word and marks every page used; no item is taken meanwhile.
// Each item then works alone. A request reads each bitmap word it enters and
// checks one page per cycle inside it, so its cost is set by a single page
// step through the memory: allocate-anywhere scans pages from zero until the
// run is found, then marks it page by page, or reports no room at the map end;
// allocate-at checks then marks its run; free touches each page once.
// Range errors skip the scan and go straight to the done state. The answer
// waits in an output register, and the next item is accepted as soon as that
// register is taken or empty.
`default_nettype none
module page_bitmap_allocator_unit
  import pba_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_opcode,
  input  wire logic [PAGE_W-1:0]  in_start_page,
  input  wire logic [COUNT_W-1:0] in_page_count,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [2:0]              out_status,
  output logic [PAGE_W-1:0]       out_result_page
);
  localparam int CUR_W = $clog2(NUM_PAGES) + 1;

  pba_state_t state_r, state_nxt;
  logic [1:0]         op_r, op_nxt;
  logic [CUR_W-1:0]   cur_r, cur_nxt;       // page being looked at
  logic [CUR_W-1:0]   left_r, left_nxt;     // pages left in the run
  logic [CUR_W-1:0]   run_r, run_nxt;       // free pages found in a row
  logic [CUR_W-1:0]   first_r, first_nxt;   // first page of the run
  logic [CUR_W-1:0]   cnt_r, cnt_nxt;
  logic               flag_r, flag_nxt;     // a free page was seen while freeing
  logic               rd_ok_r, rd_ok_nxt;   // local word copy is for word of cur_r
  logic [MAP_WORD_BITS-1:0] word_r, word_nxt; // local copy of the current word
  logic [WADDR_W-1:0] wa_r, wa_nxt;
  logic               ovalid_r, ovalid_nxt;
  logic [2:0]         ost_r, ost_nxt;
  logic [PAGE_W-1:0]  opage_r, opage_nxt;

  logic                     we;
  logic [WADDR_W-1:0]       waddr, raddr;
  logic [MAP_WORD_BITS-1:0] wdata, rdata;

  pba_map_ram u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic               accept;
  logic [CUR_W:0]     end_sum;
  logic [WADDR_W-1:0] cur_w;
  logic [BIT_W-1:0]   cur_b;
  logic               bitv;
  logic [MAP_WORD_BITS-1:0] word_cur;

  assign in_stall  = (state_r != S_IDLE) || (ovalid_r && out_stall);
  assign accept    = in_valid && !in_stall;
  assign out_valid = ovalid_r;
  assign out_status = ost_r;
  assign out_result_page = opage_r;
  assign cur_w = cur_r[BIT_W +: WADDR_W];
  assign cur_b = cur_r[BIT_W-1:0];
  assign end_sum = {{(CUR_W+1-PAGE_W){1'b0}}, in_start_page} +
                   {{(CUR_W+1-COUNT_W){1'b0}}, in_page_count};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      ovalid_r <= 1'b0;
      cur_r    <= '0;
      rd_ok_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
      cur_r    <= cur_nxt;
      rd_ok_r  <= rd_ok_nxt;
    end
    op_r <= op_nxt; left_r <= left_nxt; run_r <= run_nxt; first_r <= first_nxt;
    cnt_r <= cnt_nxt; flag_r <= flag_nxt; word_r <= word_nxt; wa_r <= wa_nxt;
    ost_r <= ost_nxt; opage_r <= opage_nxt;
  end

  always_comb begin
    state_nxt = state_r; op_nxt = op_r; cur_nxt = cur_r; left_nxt = left_r;
    run_nxt = run_r; first_nxt = first_r; cnt_nxt = cnt_r; flag_nxt = flag_r;
    rd_ok_nxt = rd_ok_r; word_nxt = word_r; wa_nxt = wa_r;
    ovalid_nxt = ovalid_r && out_stall; ost_nxt = ost_r; opage_nxt = opage_r;
    we = 1'b0; waddr = wa_r; wdata = word_r; raddr = cur_w;
    // After a word change the current word comes from the memory read data, not the copy.
    word_cur = rd_ok_r ? word_r : rdata;
    bitv = word_cur[cur_b];

    case (state_r)
      S_CLEAR: begin
        we = 1'b1; waddr = cur_w; wdata = '1;
        if (cur_w == WADDR_W'(MAP_WORDS - 1)) begin
          cur_nxt = '0; state_nxt = S_IDLE;
        end else begin
          cur_nxt = cur_r + CUR_W'(MAP_WORD_BITS);
        end
      end
      S_IDLE: begin
        if (accept) begin
          op_nxt = in_opcode; cnt_nxt = in_page_count[CUR_W-1:0];
          left_nxt = in_page_count[CUR_W-1:0]; run_nxt = '0; flag_nxt = 1'b0;
          rd_ok_nxt = 1'b0;
          if (in_page_count == '0 || in_page_count > COUNT_W'(NUM_PAGES) ||
              in_opcode > OP_FREE ||
              (in_opcode != OP_ALLOC_ANY && end_sum > (CUR_W+1)'(NUM_PAGES))) begin
            ost_nxt = ST_RANGE; opage_nxt = '0; state_nxt = S_DONE;
          end else if (in_opcode == OP_ALLOC_ANY) begin
            cur_nxt = '0; state_nxt = S_SCAN;
          end else begin
            cur_nxt = CUR_W'(in_start_page); first_nxt = CUR_W'(in_start_page);
            state_nxt = (in_opcode == OP_FREE) ? S_MARK : S_SCAN;
          end
        end
        // Fetch the word of the first page so its data is ready when the scan or mark state starts.
        raddr = cur_nxt[BIT_W +: WADDR_W];
      end
      S_SCAN: begin
        // Check one page. Leaving a word makes the next page use the fresh memory read.
        word_nxt = word_cur; rd_ok_nxt = 1'b1;
        if (cur_b == BIT_W'(MAP_WORD_BITS - 1)) rd_ok_nxt = 1'b0;
        cur_nxt = cur_r + CUR_W'(1);
        raddr = cur_nxt[BIT_W +: WADDR_W];
        if (op_r == OP_ALLOC_ANY) begin
          if (bitv) begin
            run_nxt = '0;
          end else begin
            run_nxt = run_r + CUR_W'(1);
            if (run_nxt == cnt_r) begin
              first_nxt = cur_r + CUR_W'(1) - cnt_r;
              cur_nxt = cur_r + CUR_W'(1) - cnt_r; left_nxt = cnt_r;
              rd_ok_nxt = 1'b0; state_nxt = S_MARK;
            end
          end
          if (state_nxt == S_SCAN && cur_nxt == CUR_W'(NUM_PAGES)) begin
            ost_nxt = ST_NO_ROOM; opage_nxt = '0; state_nxt = S_DONE;
          end
        end else begin
          if (bitv) begin
            ost_nxt = ST_USED; opage_nxt = '0; state_nxt = S_DONE;
          end else if (left_r == CUR_W'(1)) begin
            cur_nxt = first_r; left_nxt = cnt_r; rd_ok_nxt = 1'b0;
            state_nxt = S_MARK;
          end else begin
            left_nxt = left_r - CUR_W'(1);
          end
        end
        if (state_nxt != S_SCAN) raddr = cur_nxt[BIT_W +: WADDR_W];
      end
      S_MARK: begin
        // Modify the word copy; write it back at a word edge or the run end.
        word_nxt = word_cur;
        if (op_r == OP_FREE) begin
          if (!bitv) flag_nxt = 1'b1;
          word_nxt[cur_b] = 1'b0;
        end else begin
          word_nxt[cur_b] = 1'b1;
        end
        rd_ok_nxt = 1'b1; wa_nxt = cur_w;
        cur_nxt = cur_r + CUR_W'(1); left_nxt = left_r - CUR_W'(1);
        raddr = cur_nxt[BIT_W +: WADDR_W];
        if (left_r == CUR_W'(1) || cur_b == BIT_W'(MAP_WORD_BITS - 1)) begin
          we = 1'b1; waddr = cur_w; wdata = word_nxt; rd_ok_nxt = 1'b0;
        end
        if (left_r == CUR_W'(1)) begin
          ost_nxt = (op_r == OP_FREE && flag_nxt) ? ST_FREED_FREE : ST_OK;
          opage_nxt = first_r[PAGE_W-1:0]; state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        ovalid_nxt = 1'b1; state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

`ifndef SYNTH
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> state_r == S_IDLE) else $error("item accepted while busy");
  a_done_gives_out: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE |=> out_valid) else $error("result lost");
  a_write_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> (state_r == S_CLEAR || state_r == S_MARK)) else $error("stray map write");
`endif
endmodule
`default_nettype wire

@@ sv/pba_map_ram.sv @@
// Bitmap word memory: one write port, one registered read port.
`default_nettype none
module pba_map_ram
  import pba_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [WADDR_W-1:0]       waddr,
  input  wire logic [MAP_WORD_BITS-1:0] wdata,
  input  wire logic [WADDR_W-1:0]       raddr,
  output logic      [MAP_WORD_BITS-1:0] rdata
);
  logic [MAP_WORD_BITS-1:0] mem [MAP_WORDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ sim/tb.sv @@
// Self-checking testbench for the page bitmap allocator, directed table then random requests.
`default_nettype none
module tb
  import pba_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles without any accepted item or taken answer before the run is declared hung.
  // The slowest request scans and marks the whole map, plus stalls.
  localparam int HANG_LIMIT = 100000;
  localparam int HOLD_CYCLES = 500;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         in_opcode;
  logic [PAGE_W-1:0]  in_start_page;
  logic [COUNT_W-1:0] in_page_count;
  logic               out_valid;
  logic               out_stall;
  logic [2:0]         out_status;
  logic [PAGE_W-1:0]  out_result_page;

  page_bitmap_allocator_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_opcode(in_opcode),
    .in_start_page(in_start_page), .in_page_count(in_page_count),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_result_page(out_result_page)
  );

  // One row of the directed table. When known is set, the answer is typed in.
  typedef struct {
    logic [1:0]         op;
    logic [PAGE_W-1:0]  start;
    logic [COUNT_W-1:0] cnt;
    bit                 known;
    logic [2:0]         st;
    logic [PAGE_W-1:0]  pg;
  } request_row_t;

  typedef struct {
    logic [2:0]        st;
    logic [PAGE_W-1:0] pg;
  } answer_t;

  bit [NUM_PAGES-1:0] page_map;   // The testbench's own copy of the in-use bits.
  answer_t            answer_q[$];
  request_row_t       dir_rows[$];

  int error_count;
  int items_sent;
  int answers_seen;
  int idle_cycles;
  int tx_pct;
  int rx_pct;
  bit hold_request;
  int hold_left;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Computes the answer to one request and applies its effect on the page map.
  function automatic answer_t predict_answer(input logic [1:0] op,
                                             input logic [PAGE_W-1:0] start,
                                             input logic [COUNT_W-1:0] cnt);
    answer_t a;
    int run;
    int first;
    bit clash;
    bit was_free;
    a.st = ST_RANGE;
    a.pg = '0;
    if (cnt == 0 || int'(cnt) > NUM_PAGES || op > OP_FREE) begin
      a.st = ST_RANGE;
    end else if (op == OP_ALLOC_ANY) begin
      run = 0;
      a.st = ST_NO_ROOM;
      for (int i = 0; i < NUM_PAGES; i++) begin
        if (page_map[i]) begin
          run = 0;
        end else begin
          run++;
          if (run == int'(cnt)) begin
            first = i + 1 - int'(cnt);
            for (int j = first; j <= i; j++) page_map[j] = 1'b1;
            a.st = ST_OK;
            a.pg = first[PAGE_W-1:0];
            break;
          end
        end
      end
    end else if (int'(start) + int'(cnt) > NUM_PAGES) begin
      a.st = ST_RANGE;
    end else if (op == OP_ALLOC_AT) begin
      clash = 1'b0;
      for (int i = 0; i < int'(cnt); i++) if (page_map[int'(start) + i]) clash = 1'b1;
      if (clash) begin
        a.st = ST_USED;
      end else begin
        for (int i = 0; i < int'(cnt); i++) page_map[int'(start) + i] = 1'b1;
        a.st = ST_OK;
        a.pg = start;
      end
    end else begin
      was_free = 1'b0;
      for (int i = 0; i < int'(cnt); i++) begin
        if (!page_map[int'(start) + i]) was_free = 1'b1;
        page_map[int'(start) + i] = 1'b0;
      end
      a.st = was_free ? ST_FREED_FREE : ST_OK;
      a.pg = start;
    end
    return a;
  endfunction

  function automatic void dir_row(input logic [1:0] op, input int start, input int cnt,
                                  input bit known, input logic [2:0] st, input int pg);
    request_row_t r;
    r.op = op;
    r.start = start[PAGE_W-1:0];
    r.cnt = cnt[COUNT_W-1:0];
    r.known = known;
    r.st = st;
    r.pg = pg[PAGE_W-1:0];
    dir_rows.push_back(r);
  endfunction

  // Offers one item, with random idle cycles first, and records the expected answer
  // at the edge where the block takes it. Valid only changes at falling edges.
  task automatic send_item(input logic [1:0] op, input logic [PAGE_W-1:0] start,
                           input logic [COUNT_W-1:0] cnt, input bit known,
                           input logic [2:0] st, input logic [PAGE_W-1:0] pg);
    answer_t a;
    while ($urandom_range(0, 99) < tx_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
      in_opcode <= 2'($urandom);
      in_start_page <= PAGE_W'($urandom);
      in_page_count <= COUNT_W'($urandom);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_opcode <= op;
    in_start_page <= start;
    in_page_count <= cnt;
    do @(posedge clk); while (!(in_valid && !in_stall));
    a = predict_answer(op, start, cnt);
    if (known && (a.st !== st || a.pg !== pg)) begin
      $display("%0t: table row op %0d start %0d count %0d: expected %0d/%0d, predicted %0d/%0d",
               $time, op, start, cnt, st, pg, a.st, a.pg);
      error_count++;
    end
    answer_q.push_back(a);
    items_sent++;
  endtask

  // Random page run: mostly low pages with short runs so first-fit scans stay short.
  task automatic random_item();
    int r;
    int start;
    int cnt;
    logic [1:0] op;
    r = $urandom_range(0, 99);
    start = ($urandom_range(0, 9) == 0) ? $urandom_range(0, NUM_PAGES - 1)
                                        : $urandom_range(0, 255);
    cnt = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 300) : $urandom_range(1, 16);
    if (start + cnt > NUM_PAGES) cnt = NUM_PAGES - start;
    if (r < 8) begin
      // Malformed requests: unknown opcode, zero count or a run past the end.
      case ($urandom_range(0, 2))
        0: begin
          op = 2'd3;
          cnt = $urandom_range(0, 8191);
        end
        1: begin
          op = 2'($urandom_range(0, 2));
          cnt = 0;
        end
        default: begin
          op = 2'($urandom_range(0, 2));
          start = $urandom_range(3900, NUM_PAGES - 1);
          cnt = (op == OP_ALLOC_ANY) ? $urandom_range(NUM_PAGES + 1, 8191)
                                     : $urandom_range(NUM_PAGES - start + 1, 8191);
        end
      endcase
    end else if (r < 10) begin
      op = OP_FREE;
      start = 0;
      cnt = 1024;
    end else if (r < 48) begin
      op = OP_FREE;
    end else if (r < 68) begin
      op = OP_ALLOC_AT;
    end else begin
      op = OP_ALLOC_ANY;
    end
    send_item(op, start[PAGE_W-1:0], cnt[COUNT_W-1:0], 1'b0, ST_OK, '0);
  endtask

  // Receiver: random stalls at the phase's rate, or one long hold-off on request.
  always @(negedge clk) begin
    if (hold_request && hold_left == 0) begin
      hold_left <= HOLD_CYCLES;
      hold_request <= 1'b0;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_pct);
    end
  end

  // Result checker and hang watchdog; both look at values from before the edge.
  always @(posedge clk) begin
    answer_t e;
    if (rst_n && out_valid && !out_stall) begin
      answers_seen++;
      if (answer_q.size() == 0) begin
        $display("%0t: unexpected answer status %0d page %0d", $time, out_status,
                 out_result_page);
        error_count++;
      end else begin
        e = answer_q.pop_front();
        if (out_status !== e.st) begin
          $display("%0t: status expected %0d actual %0d", $time, e.st, out_status);
          error_count++;
        end
        if (out_result_page !== e.pg) begin
          $display("%0t: result_page expected %0d actual %0d", $time, e.pg, out_result_page);
          error_count++;
        end
      end
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= HANG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d answers still due", $time,
               HANG_LIMIT, answer_q.size());
      $display("tb: FAIL");
      $finish;
    end
  end

  initial begin
    int settle;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_opcode = '0;
    in_start_page = '0;
    in_page_count = '0;
    out_stall = 1'b0;
    error_count = 0;
    items_sent = 0;
    answers_seen = 0;
    idle_cycles = 0;
    tx_pct = 0;
    rx_pct = 0;
    hold_request = 1'b0;
    hold_left = 0;
    page_map = '1;

    // After reset every page is in use, so the first requests find nothing free.
    dir_row(OP_ALLOC_ANY, 0, 1, 1, ST_NO_ROOM, 0);
    dir_row(OP_ALLOC_AT, 0, 1, 1, ST_USED, 0);
    dir_row(OP_FREE, 0, NUM_PAGES, 1, ST_OK, 0);
    dir_row(OP_FREE, 0, 1, 1, ST_FREED_FREE, 0);
    dir_row(OP_ALLOC_ANY, 0, 0, 1, ST_RANGE, 0);
    dir_row(2'd3, 5, 1, 1, ST_RANGE, 0);
    dir_row(OP_ALLOC_AT, 4095, 2, 1, ST_RANGE, 0);
    dir_row(OP_FREE, 4095, 8191, 1, ST_RANGE, 0);
    dir_row(OP_ALLOC_ANY, 4095, NUM_PAGES + 1, 1, ST_RANGE, 0);
    dir_row(OP_ALLOC_ANY, 0, 8191, 1, ST_RANGE, 0);
    dir_row(OP_FREE, 4095, 1, 1, ST_FREED_FREE, 4095);
    dir_row(OP_ALLOC_ANY, 0, NUM_PAGES, 1, ST_OK, 0);
    dir_row(OP_ALLOC_ANY, 0, 1, 1, ST_NO_ROOM, 0);
    dir_row(OP_FREE, 4095, 1, 1, ST_OK, 4095);
    dir_row(OP_ALLOC_AT, 4095, 1, 1, ST_OK, 4095);
    dir_row(OP_FREE, 0, NUM_PAGES, 1, ST_OK, 0);
    dir_row(OP_ALLOC_AT, 0, NUM_PAGES, 1, ST_OK, 0);
    dir_row(OP_FREE, 2048, 2048, 1, ST_OK, 2048);
    dir_row(OP_ALLOC_ANY, 0, 2049, 1, ST_NO_ROOM, 0);
    dir_row(OP_ALLOC_ANY, 0, 2048, 1, ST_OK, 2048);
    dir_row(OP_FREE, 100, 50, 0, ST_OK, 0);
    dir_row(OP_ALLOC_AT, 120, 10, 0, ST_OK, 0);
    dir_row(OP_ALLOC_ANY, 0, 7, 0, ST_OK, 0);
    dir_row(OP_FREE, 0, 300, 0, ST_OK, 0);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i])
      send_item(dir_rows[i].op, dir_rows[i].start, dir_rows[i].cnt, dir_rows[i].known,
                dir_rows[i].st, dir_rows[i].pg);

    // Four idling phases; the first one also holds the receiver off for a long stretch.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin tx_pct = 0;  rx_pct = 0;  end
        1: begin tx_pct = 48; rx_pct = 0;  end
        2: begin tx_pct = 0;  rx_pct = 48; end
        default: begin tx_pct = 13; rx_pct = 13; end
      endcase
      for (int n = 0; n < 406; n++) begin
        if (ph == 0 && n == 20) hold_request = 1'b1;
        random_item();
      end
    end
    @(negedge clk);
    in_valid <= 1'b0;

    wait (answer_q.size() == 0);
    settle = 0;
    while (settle < 20) begin
      @(posedge clk);
      settle++;
    end

    $display("tb: %0d requests sent, %0d answers checked over four idling phases",
             items_sent, answers_seen);
    $display("tb: covered first fit, allocate-at, free, range errors and a long output stall");
    if (error_count == 0 && answer_q.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
